@@ rtl/time_ordered_source_queue_core_assert.svh @@
// Assertion macros used by the queue core RTL.
// Depends on a clock named aclk and an active-low reset named aresetn in the using module.
`ifndef TIME_ORDERED_SOURCE_QUEUE_CORE_ASSERT_SVH
`define TIME_ORDERED_SOURCE_QUEUE_CORE_ASSERT_SVH

// Property checked at every clock edge while reset is released.
`define TOSQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Implication checked on the edge after the antecedent holds.
`define TOSQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/tosq_pkg.sv @@
// Package for the time-ordered source queue: sizes, codes and shared types.
// Used by tosq_cell and the queue core; depends on nothing.
package tosq_pkg;

    localparam int DEPTH     = 16;
    localparam int KEY_W     = 32;
    localparam int HND_W     = 16;
    localparam int CNT_FLD_W = 5;
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int IDX_W     = $clog2(DEPTH);
    localparam int PASS_W    = $clog2(DEPTH);
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 56;

    typedef enum logic [2:0] {
        ACT_PUT   = 3'd0,
        ACT_GET   = 3'd1,
        ACT_SORT  = 3'd2,
        ACT_FLUSH = 3'd3,
        ACT_SIZE  = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        STAT_OK     = 2'd0,
        STAT_EMPTY  = 2'd1,
        STAT_REJECT = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SORT,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_SHIFT,
        CELL_SORT
    } cell_cmd_t;

    // Command broadcast from the controller to every cell of the chain.
    typedef struct packed {
        cell_cmd_t          cmd;
        logic               phase;
        logic [CNT_W-1:0]   count;
        logic [KEY_W-1:0]   key;
        logic [HND_W-1:0]   handle;
    } cell_ctrl_t;

    typedef struct packed {
        logic [CNT_FLD_W-1:0] count;
        logic [HND_W-1:0]     handle;
        logic [KEY_W-1:0]     key;
        status_t              status;
    } result_t;

    // Low bits of the entry count as carried in the result.
    function automatic logic [CNT_FLD_W-1:0] count_field(input logic [CNT_W-1:0] c);
        logic [CNT_W+CNT_FLD_W-1:0] wide;
        wide = {{CNT_FLD_W{1'b0}}, c};
        return wide[CNT_FLD_W-1:0];
    endfunction

endpackage

@@ rtl/tosq_cell.sv @@
// One slot of the queue chain: holds a key and a handle and trades them with its neighbors.
// Depends on tosq_pkg for the command struct and field widths.
module tosq_cell (
    input  logic                         aclk,
    input  tosq_pkg::cell_ctrl_t         ctrl,
    input  logic [tosq_pkg::IDX_W-1:0]   idx,
    input  logic [tosq_pkg::KEY_W-1:0]   right_key,
    input  logic [tosq_pkg::HND_W-1:0]   right_handle,
    input  logic [tosq_pkg::KEY_W-1:0]   left_key,
    input  logic [tosq_pkg::HND_W-1:0]   left_handle,
    input  logic                         left_gt,
    output logic [tosq_pkg::KEY_W-1:0]   key_q,
    output logic [tosq_pkg::HND_W-1:0]   handle_q,
    output logic                         gt_right
);

    logic [tosq_pkg::KEY_W-1:0] key_reg, key_next;
    logic [tosq_pkg::HND_W-1:0] handle_reg, handle_next;
    logic [tosq_pkg::CNT_W-1:0] idx_ext;
    logic                       left_member;
    logic                       right_member;

    // Pair membership for the current odd-even exchange pass.
    assign idx_ext      = tosq_pkg::CNT_W'(idx);
    assign left_member  = (idx[0] == ctrl.phase)
                          && ((idx_ext + tosq_pkg::CNT_W'(1)) < ctrl.count);
    assign right_member = (idx[0] != ctrl.phase) && (idx != '0)
                          && (idx_ext < ctrl.count);
    assign gt_right     = key_reg > right_key;

    // Select the slot contents for the next cycle.
    always_comb begin
        key_next    = key_reg;
        handle_next = handle_reg;
        case (ctrl.cmd)
            tosq_pkg::CELL_LOAD: begin
                if (idx_ext == ctrl.count) begin
                    key_next    = ctrl.key;
                    handle_next = ctrl.handle;
                end
            end
            tosq_pkg::CELL_SHIFT: begin
                key_next    = right_key;
                handle_next = right_handle;
            end
            tosq_pkg::CELL_SORT: begin
                // Strict compare keeps equal keys in order.
                if (left_member && gt_right) begin
                    key_next    = right_key;
                    handle_next = right_handle;
                end else if (right_member && left_gt) begin
                    key_next    = left_key;
                    handle_next = left_handle;
                end
            end
            default: begin
                key_next    = key_reg;
                handle_next = handle_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        key_reg    <= key_next;
        handle_reg <= handle_next;
    end

    assign key_q    = key_reg;
    assign handle_q = handle_reg;

endmodule

@@ rtl/time_ordered_source_queue_core.sv @@
// Time-ordered source queue: up to DEPTH entries (32-bit start-time key, 16-bit handle)
// held in a chain of slot cells. Put, get, flush and size are taken one per cycle while
// the result register drains, each writing its result to that register. A sort runs
// DEPTH odd-even exchange passes through the cell chain, one pass per cycle, and then
// posts its result once the output is free; no input transaction is taken until then.
// The sort is stable: equal keys keep their arrival order.
// Depends on tosq_pkg, tosq_cell and time_ordered_source_queue_core_assert.svh.
`include "time_ordered_source_queue_core_assert.svh"

module time_ordered_source_queue_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // action [2:0], key_time_ms [34:3], payload_handle [50:35], source_valid [51], zero pad
    input  logic [tosq_pkg::IN_TDATA_W-1:0]     s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // status [1:0], out_key_time_ms [33:2], out_payload_handle [49:34], count [54:50], pad
    output logic [tosq_pkg::OUT_TDATA_W-1:0]    m_tdata
);

    localparam int RES_W = $bits(tosq_pkg::result_t);

    tosq_pkg::state_t            state_reg, state_next;
    logic [tosq_pkg::PASS_W-1:0] pass_reg, pass_next;
    logic [tosq_pkg::CNT_W-1:0]  count_reg, count_next;
    logic                        m_valid_reg, m_valid_next;
    tosq_pkg::result_t           res_reg, res_next;
    tosq_pkg::cell_ctrl_t        cell_ctrl;

    tosq_pkg::action_t           in_action;
    logic [tosq_pkg::KEY_W-1:0]  in_key;
    logic [tosq_pkg::HND_W-1:0]  in_handle;
    logic                        in_source_valid;
    logic                        in_acc;
    logic                        out_free;

    logic                        sort_acc;
    logic                        sort_busy;
    logic                        sort_first;
    logic                        sort_last;

    logic [tosq_pkg::KEY_W-1:0]  slot_key    [tosq_pkg::DEPTH];
    logic [tosq_pkg::HND_W-1:0]  slot_handle [tosq_pkg::DEPTH];
    logic                        slot_gt     [tosq_pkg::DEPTH];

    // Unpack the input transaction.
    assign in_action       = tosq_pkg::action_t'(s_tdata[2:0]);
    assign in_key          = s_tdata[34:3];
    assign in_handle       = s_tdata[50:35];
    assign in_source_valid = s_tdata[51];

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == tosq_pkg::ST_IDLE) && out_free;
    assign in_acc   = s_tvalid && s_tready;

    // Chain of slot cells; slot 0 is the head.
    for (genvar i = 0; i < tosq_pkg::DEPTH; i++) begin : g_cell
        logic [tosq_pkg::KEY_W-1:0] r_key, l_key;
        logic [tosq_pkg::HND_W-1:0] r_handle, l_handle;
        logic                       l_gt;

        if (i == tosq_pkg::DEPTH - 1) begin : g_tail
            assign r_key    = '0;
            assign r_handle = '0;
        end else begin : g_mid
            assign r_key    = slot_key[i+1];
            assign r_handle = slot_handle[i+1];
        end

        if (i == 0) begin : g_head
            assign l_key    = '0;
            assign l_handle = '0;
            assign l_gt     = 1'b0;
        end else begin : g_body
            assign l_key    = slot_key[i-1];
            assign l_handle = slot_handle[i-1];
            assign l_gt     = slot_gt[i-1];
        end

        tosq_cell u_cell (
            .aclk         (aclk),
            .ctrl         (cell_ctrl),
            .idx          (tosq_pkg::IDX_W'(i)),
            .right_key    (r_key),
            .right_handle (r_handle),
            .left_key     (l_key),
            .left_handle  (l_handle),
            .left_gt      (l_gt),
            .key_q        (slot_key[i]),
            .handle_q     (slot_handle[i]),
            .gt_right     (slot_gt[i])
        );
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            tosq_pkg::ST_IDLE: begin
                if (in_acc && (in_action == tosq_pkg::ACT_SORT)) begin
                    state_next = tosq_pkg::ST_SORT;
                end
            end
            tosq_pkg::ST_SORT: begin
                if (pass_reg == tosq_pkg::PASS_W'(tosq_pkg::DEPTH - 1)) begin
                    state_next = tosq_pkg::ST_DONE;
                end
            end
            tosq_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = tosq_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = tosq_pkg::ST_IDLE;
            end
        endcase
    end

    // Cell commands, count update and result formation.
    always_comb begin
        cell_ctrl.cmd    = tosq_pkg::CELL_HOLD;
        cell_ctrl.phase  = pass_reg[0];
        cell_ctrl.count  = count_reg;
        cell_ctrl.key    = in_key;
        cell_ctrl.handle = in_handle;
        count_next       = count_reg;
        pass_next        = pass_reg;
        m_valid_next     = m_valid_reg && !m_tready;
        res_next         = res_reg;

        case (state_reg)
            tosq_pkg::ST_IDLE: begin
                if (in_acc) begin
                    res_next.status = tosq_pkg::STAT_OK;
                    res_next.key    = '0;
                    res_next.handle = '0;
                    m_valid_next    = 1'b1;
                    case (in_action)
                        tosq_pkg::ACT_PUT: begin
                            if (in_source_valid
                                && (count_reg < tosq_pkg::CNT_W'(tosq_pkg::DEPTH))) begin
                                cell_ctrl.cmd = tosq_pkg::CELL_LOAD;
                                count_next    = count_reg + tosq_pkg::CNT_W'(1);
                            end else begin
                                res_next.status = tosq_pkg::STAT_REJECT;
                            end
                        end
                        tosq_pkg::ACT_GET: begin
                            if (count_reg == '0) begin
                                res_next.status = tosq_pkg::STAT_EMPTY;
                            end else begin
                                res_next.key    = slot_key[0];
                                res_next.handle = slot_handle[0];
                                cell_ctrl.cmd   = tosq_pkg::CELL_SHIFT;
                                count_next      = count_reg - tosq_pkg::CNT_W'(1);
                            end
                        end
                        tosq_pkg::ACT_SORT: begin
                            m_valid_next = 1'b0;
                            pass_next    = '0;
                        end
                        tosq_pkg::ACT_FLUSH: begin
                            count_next = '0;
                        end
                        default: begin
                            count_next = count_reg;
                        end
                    endcase
                    res_next.count = tosq_pkg::count_field(count_next);
                end
            end
            tosq_pkg::ST_SORT: begin
                cell_ctrl.cmd = tosq_pkg::CELL_SORT;
                pass_next     = pass_reg + tosq_pkg::PASS_W'(1);
            end
            tosq_pkg::ST_DONE: begin
                if (out_free) begin
                    m_valid_next    = 1'b1;
                    res_next.status = tosq_pkg::STAT_OK;
                    res_next.key    = '0;
                    res_next.handle = '0;
                    res_next.count  = tosq_pkg::count_field(count_reg);
                end
            end
            default: begin
                cell_ctrl.cmd = tosq_pkg::CELL_HOLD;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= tosq_pkg::ST_IDLE;
            pass_reg    <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pass_reg    <= pass_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        res_reg <= res_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(tosq_pkg::OUT_TDATA_W - RES_W){1'b0}}, res_reg};

    // Sort sequencing terms watched by the checks below.
    assign sort_acc   = in_acc && (in_action == tosq_pkg::ACT_SORT);
    assign sort_busy  = state_reg != tosq_pkg::ST_IDLE;
    assign sort_first = (state_reg == tosq_pkg::ST_SORT) && (pass_reg == '0);
    assign sort_last  = (state_reg == tosq_pkg::ST_SORT)
                        && (pass_reg == tosq_pkg::PASS_W'(tosq_pkg::DEPTH - 1));

    // The held count never passes the queue depth.
    `TOSQ_ASSERT(a_count_bound, count_reg <= tosq_pkg::CNT_W'(tosq_pkg::DEPTH), "count over depth")
    // The count only changes through a transaction taken while idle.
    `TOSQ_ASSERT_NEXT(a_count_frozen, sort_busy, $stable(count_reg), "count moved during sort")
    // An accepted sort starts the exchange passes.
    `TOSQ_ASSERT_NEXT(a_sort_start, sort_acc, sort_first, "sort did not start")
    // The last exchange pass hands over to result posting.
    `TOSQ_ASSERT_NEXT(a_sort_end, sort_last, state_reg == tosq_pkg::ST_DONE, "sort overran")

endmodule
